@@ rtl/core/mazebt_pkg.sv @@
`timescale 1ns / 1ps

package mazebt_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DECIDE,
        ST_POP,
        ST_EMIT
    } mazebt_state_t;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_CARVE   = 2'd1;
    localparam logic [1:0] ACT_BACK    = 2'd2;
    localparam logic [1:0] ACT_FINISH  = 2'd3;

    localparam logic [1:0] SIDE_UP    = 2'd0;
    localparam logic [1:0] SIDE_DOWN  = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd2;
    localparam logic [1:0] SIDE_RIGHT = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic start_restart;
        logic start_step;
        logic scan;
        logic decide;
        logic pop_load;
        logic emit;
    } mazebt_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic carve_ok;
        logic stack_nz;
        logic out_free;
    } mazebt_stat_t;

endpackage

@@ rtl/core/mazebt_ctrl.sv @@
`timescale 1ns / 1ps

module mazebt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_opcode,
    output logic                 s_tready,
    input  mazebt_pkg::mazebt_stat_t stat,
    output mazebt_pkg::mazebt_cmd_t  cmd
);
    import mazebt_pkg::*;

    mazebt_state_t state_reg, state_next;
    logic          restart_reg, restart_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            restart_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            restart_reg <= restart_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        restart_next = restart_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = restart_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_opcode == OP_RESTART) begin
                        state_next   = ST_CLEAR;
                        restart_next = 1'b1;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = (!stat.carve_ok && stat.stack_nz) ? ST_POP : ST_EMIT;
            ST_POP:    state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start_restart = (s_opcode == OP_RESTART);
                    cmd.start_step    = (s_opcode == OP_STEP);
                end
            end
            ST_SCAN:   cmd.scan = 1'b1;
            ST_TAIL:   cmd = '0;
            ST_DECIDE: cmd.decide = 1'b1;
            ST_POP:    cmd.pop_load = 1'b1;
            ST_EMIT:   cmd.emit = stat.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/mazebt_dp.sv @@
`timescale 1ns / 1ps

module mazebt_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mazebt_pkg::mazebt_cmd_t  cmd,
    output mazebt_pkg::mazebt_stat_t stat,
    input  logic [7:0]               rand_pick,
    input  logic [6:0]               maze_width,
    input  logic [6:0]               maze_height,
    input  logic                     m_tready,
    output logic                     m_valid,
    output logic [1:0]               m_action,
    output logic [5:0]               m_from_x,
    output logic [5:0]               m_from_y,
    output logic [5:0]               m_to_x,
    output logic [5:0]               m_to_y,
    output logic [1:0]               m_wall_side
);
    import mazebt_pkg::*;

    localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int CW      = ((XW > YW) ? XW : YW) + 1;
    localparam int DCW     = (CW > 7) ? CW : 7;
    localparam int SW      = XW + YW;

    // grid size, clamped
    logic [CW-1:0] w_eff, h_eff;

    always_comb begin
        if (maze_width == 7'd0) begin
            w_eff = CW'(1);
        end else if (DCW'(maze_width) > DCW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(maze_width);
        end
        if (maze_height == 7'd0) begin
            h_eff = CW'(1);
        end else if (DCW'(maze_height) > DCW'(MAX_HEIGHT)) begin
            h_eff = CW'(MAX_HEIGHT);
        end else begin
            h_eff = CW'(maze_height);
        end
    end

    logic [XW-1:0]      cur_x_reg, from_x_reg;
    logic [YW-1:0]      cur_y_reg, from_y_reg;
    logic [CELL_AW:0]   depth_reg;
    logic [CELL_AW-1:0] clr_cnt_reg;
    logic [7:0]         pick_reg;
    logic [1:0]         dir_reg;
    logic [3:0]         mask_reg;
    logic               cap_valid_reg;
    logic [1:0]         cap_dir_reg;
    logic               cap_in_reg;
    logic [1:0]         res_action_reg;
    logic [1:0]         res_side_reg;

    function automatic logic [XW-1:0] nb_x(input logic [1:0] s, input logic [XW-1:0] x);
        logic [XW-1:0] r;
        unique case (s)
            SIDE_LEFT:  r = x - XW'(1);
            SIDE_RIGHT: r = x + XW'(1);
            default:    r = x;
        endcase
        return r;
    endfunction

    function automatic logic [YW-1:0] nb_y(input logic [1:0] s, input logic [YW-1:0] y);
        logic [YW-1:0] r;
        unique case (s)
            SIDE_UP:   r = y - YW'(1);
            SIDE_DOWN: r = y + YW'(1);
            default:   r = y;
        endcase
        return r;
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                     input logic [YW-1:0] y);
        return CELL_AW'(y) * CELL_AW'(MAX_WIDTH) + CELL_AW'(x);
    endfunction

    // neighbour lies inside the grid
    logic [CW-1:0] xe, ye;
    logic [3:0]    in_grid;

    always_comb begin
        xe = CW'(cur_x_reg);
        ye = CW'(cur_y_reg);
        in_grid[SIDE_UP]    = (ye != '0) && (ye - CW'(1) < h_eff) && (xe < w_eff);
        in_grid[SIDE_DOWN]  = (ye + CW'(1) < h_eff) && (xe < w_eff);
        in_grid[SIDE_LEFT]  = (xe != '0) && (xe - CW'(1) < w_eff) && (ye < h_eff);
        in_grid[SIDE_RIGHT] = (xe + CW'(1) < w_eff) && (ye < h_eff);
    end

    // choose among candidates
    logic [2:0]  cand_count;
    logic [10:0] pick_prod;
    logic [1:0]  pick_k;
    logic [1:0]  side_sel;
    logic [2:0]  seen;

    always_comb begin
        cand_count = 3'(mask_reg[0]) + 3'(mask_reg[1]) + 3'(mask_reg[2]) + 3'(mask_reg[3]);
        pick_prod  = 11'(pick_reg) * 11'(cand_count);
        pick_k     = pick_prod[9:8];
        side_sel   = SIDE_UP;
        seen       = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (mask_reg[i]) begin
                if (seen == {1'b0, pick_k}) begin
                    side_sel = 2'(i);
                end
                seen = seen + 3'd1;
            end
        end
    end

    logic [XW-1:0]      carve_x;
    logic [YW-1:0]      carve_y;
    logic               carve_ok;
    logic               push_ok;

    assign carve_x  = nb_x(side_sel, cur_x_reg);
    assign carve_y  = nb_y(side_sel, cur_y_reg);
    assign carve_ok = (mask_reg != 4'd0);
    assign push_ok  = (depth_reg < (CELL_AW + 1)'(CELLS));

    // visited store
    logic               vis_mem [CELLS];
    logic               vis_we, vis_wd, vis_rdata_reg;
    logic [CELL_AW-1:0] vis_wa, vis_ra;

    always_comb begin
        vis_we = cmd.clr_step || (cmd.decide && carve_ok);
        vis_wa = cmd.clr_step ? clr_cnt_reg : cell_addr(carve_x, carve_y);
        vis_wd = cmd.clr_step ? (clr_cnt_reg == '0) : 1'b1;
        vis_ra = in_grid[dir_reg] ?
                 cell_addr(nb_x(dir_reg, cur_x_reg), nb_y(dir_reg, cur_y_reg)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        vis_rdata_reg <= vis_mem[vis_ra];
    end

    // path stack, {y, x}
    logic [SW-1:0]      stk_mem [CELLS];
    logic [SW-1:0]      stk_rdata_reg;
    logic               stk_we;
    logic [CELL_AW-1:0] stk_ra;

    assign stk_we = cmd.decide && carve_ok && push_ok;
    assign stk_ra = CELL_AW'(depth_reg - (CELL_AW + 1)'(1));

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[depth_reg[CELL_AW-1:0]] <= {cur_y_reg, cur_x_reg};
        end
        stk_rdata_reg <= stk_mem[stk_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            depth_reg     <= '0;
            clr_cnt_reg   <= '0;
            dir_reg       <= '0;
            mask_reg      <= '0;
            cap_valid_reg <= 1'b0;
            m_valid       <= 1'b0;
        end else begin
            cap_valid_reg <= cmd.scan;
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + CELL_AW'(1);
            end
            if (cmd.start_restart) begin
                cur_x_reg   <= '0;
                cur_y_reg   <= '0;
                depth_reg   <= '0;
                clr_cnt_reg <= '0;
            end
            if (cmd.start_step) begin
                dir_reg  <= '0;
                mask_reg <= '0;
            end
            if (cmd.scan) begin
                dir_reg <= dir_reg + 2'd1;
            end
            if (cap_valid_reg) begin
                mask_reg[cap_dir_reg] <= cap_in_reg && !vis_rdata_reg;
            end
            if (cmd.decide) begin
                if (carve_ok) begin
                    cur_x_reg <= carve_x;
                    cur_y_reg <= carve_y;
                    if (push_ok) begin
                        depth_reg <= depth_reg + (CELL_AW + 1)'(1);
                    end
                end else if (depth_reg != '0) begin
                    depth_reg <= depth_reg - (CELL_AW + 1)'(1);
                end
            end
            if (cmd.pop_load) begin
                cur_x_reg <= stk_rdata_reg[XW-1:0];
                cur_y_reg <= stk_rdata_reg[SW-1:XW];
            end
            if (cmd.emit) begin
                m_valid <= 1'b1;
            end else if (m_tready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cap_dir_reg <= dir_reg;
        cap_in_reg  <= in_grid[dir_reg];
        if (cmd.start_restart || cmd.start_step) begin
            from_x_reg     <= cur_x_reg;
            from_y_reg     <= cur_y_reg;
            pick_reg       <= rand_pick;
            res_action_reg <= ACT_RESTART;
            res_side_reg   <= SIDE_UP;
        end
        if (cmd.decide) begin
            if (carve_ok) begin
                res_action_reg <= ACT_CARVE;
                res_side_reg   <= side_sel;
            end else if (depth_reg != '0) begin
                res_action_reg <= ACT_BACK;
            end else begin
                res_action_reg <= ACT_FINISH;
            end
        end
        if (cmd.emit) begin
            m_action    <= res_action_reg;
            m_from_x    <= 6'(from_x_reg);
            m_from_y    <= 6'(from_y_reg);
            m_to_x      <= 6'(cur_x_reg);
            m_to_y      <= 6'(cur_y_reg);
            m_wall_side <= res_side_reg;
        end
    end

    always_comb begin
        stat.clr_last  = (clr_cnt_reg == CELL_AW'(CELLS - 1));
        stat.scan_last = (dir_reg == 2'd3);
        stat.carve_ok  = carve_ok;
        stat.stack_nz  = (depth_reg != '0);
        stat.out_free  = !m_valid || m_tready;
    end

endmodule

@@ rtl/core/maze_dfs_backtracker.sv @@
// Step item: scan, tail and decide states, plus a pop state when backtracking, come before
// the result; the four neighbour lookups share the single visited-store read port.
// Restart item: a sweep of the visited store, then the result is issued.
// One item in flight; the next is taken the cycle after the result is issued, while the
// previous result waits at the output.
// Reset: synchronous, active low; a sweep then clears the visited store and marks cell
// (0,0), with no item accepted until it ends.
`timescale 1ns / 1ps

module maze_dfs_backtracker #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rand_pick
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // from_x, from_y, to_x, to_y, wall_side, zero pad
    output logic [1:0]  m_tuser,   // [1:0] action
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);
    import mazebt_pkg::*;

    logic [6:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd16;
            height_reg <= 7'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    mazebt_cmd_t  cmd;
    mazebt_stat_t stat;
    logic [5:0]   from_x, from_y, to_x, to_y;
    logic [1:0]   wall_side, action;

    mazebt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mazebt_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .rand_pick   (s_tdata),
        .maze_width  (width_reg),
        .maze_height (height_reg),
        .m_tready    (m_tready),
        .m_valid     (m_tvalid),
        .m_action    (action),
        .m_from_x    (from_x),
        .m_from_y    (from_y),
        .m_to_x      (to_x),
        .m_to_y      (to_y),
        .m_wall_side (wall_side)
    );

    assign m_tdata = {6'd0, wall_side, to_y, to_x, from_y, from_x};
    assign m_tuser = action;

endmodule
